// File: hdl/csbk_pkg.sv
// csbk_pkg: shared types and codes for the column sort by key row block
// holds the sequencer state type, op codes, status codes and register indexes
// no dependencies
package csbk_pkg;

  // op codes of an input beat
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SORT  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // status codes of a result beat
  localparam logic [1:0] ST_WRITTEN   = 2'd0;
  localparam logic [1:0] ST_SORT_DONE = 2'd1;
  localparam logic [1:0] ST_READ_DATA = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ROWS_USED = 2'd0;
  localparam logic [1:0] CFG_COLS_USED = 2'd1;
  localparam logic [1:0] CFG_KEY_ROW   = 2'd2;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_ORD,
    S_RD_MAT,
    S_SRT_I,
    S_SRT_C,
    S_SRT_K,
    S_SRT_J,
    S_SRT_O,
    S_SRT_CMP,
    S_SRT_PUT,
    S_DONE
  } state_t;

endpackage

// File: hdl/column_sort_by_key_row.sv
// column_sort_by_key_row: stored matrix with a stable descending column sort
// holds the matrix memory, the column order memory and the sort sequencer
// depends on csbk_pkg
//
// Usage: the input channel (in_valid/in_ready) carries one op per beat:
// write element, sort columns, or read an element of the column-permuted
// matrix. Every write, sort and read returns one result beat on the output
// channel (out_valid/out_ready); op 3 is taken and returns nothing.
// The cfg_ port sets rows in use, columns in use and the key row; write it
// only while no op is in flight.
// Timing: a write or op 3 leaves the sequencer idle, so writes stream at one
// per cycle while the output register is empty or being drained, with the
// result in the output register the cycle after acceptance.
// A read does one column order memory read, then one matrix memory read,
// both with registered data.
// A sort is an insertion sort on one comparator and the two memory read
// ports; the worst case is keys strictly rising, where every column moves
// all the way to the front.
// Reset: config returns to 16/16/1, the column order to identity (valid
// bits cleared at once, no clearing pass); matrix contents stay undefined.
// A stalled receiver holds the result in the output register; a new op is
// taken only in the cycle the register is empty or being drained.
module column_sort_by_key_row
  import csbk_pkg::*;
#(
  parameter int MAX_ROWS  = 16,
  parameter int MAX_COLS  = 16,
  parameter int DATA_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration port
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [4:0]         cfg_wdata,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [3:0]         in_row_index,
  input  logic [3:0]         in_col_index,
  input  logic signed [15:0] in_element_value,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_read_value,
  output logic [3:0]         out_source_column,
  output logic [1:0]         out_status
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_COLS);
  localparam logic [AW-1:0] COLS_A = AW'(MAX_COLS);

  // matrix address of a row and a column
  function automatic logic [AW-1:0] mat_addr(logic [4:0] row, logic [CW-1:0] col);
    return AW'(row) * COLS_A + AW'(col);
  endfunction

  // configuration registers
  logic [4:0] rows_used_r;
  logic [4:0] cols_used_r;
  logic [3:0] key_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_used_r <= 5'd16;
      cols_used_r <= 5'd16;
      key_row_r   <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS_USED: rows_used_r <= cfg_wdata;
        CFG_COLS_USED: cols_used_r <= cfg_wdata;
        CFG_KEY_ROW:   key_row_r   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // effective bounds, key row and saturated read coordinates
  logic [4:0] eff_rows, eff_cols, krow, in_row5, in_col5, rd_row, rd_pos;
  logic       wr_ok;

  always_comb begin
    if (rows_used_r == 5'd0)         eff_rows = 5'd1;
    else if (rows_used_r > MAX_ROWS) eff_rows = 5'(MAX_ROWS);
    else                             eff_rows = rows_used_r;
    if (cols_used_r == 5'd0)         eff_cols = 5'd1;
    else if (cols_used_r > MAX_COLS) eff_cols = 5'(MAX_COLS);
    else                             eff_cols = cols_used_r;
    krow    = ({1'b0, key_row_r} >= eff_rows) ? eff_rows - 5'd1 : {1'b0, key_row_r};
    in_row5 = {1'b0, in_row_index};
    in_col5 = {1'b0, in_col_index};
    wr_ok   = (in_row5 < eff_rows) && (in_col5 < eff_cols);
    rd_row  = (in_row5 >= eff_rows) ? eff_rows - 5'd1 : in_row5;
    rd_pos  = (in_col5 >= eff_cols) ? eff_cols - 5'd1 : in_col5;
  end

  // matrix memory
  logic [DATA_BITS-1:0]        mat_mem [DEPTH];
  logic                        mat_we;
  logic [AW-1:0]               mat_waddr, mat_raddr;
  logic signed [DATA_BITS-1:0] mat_wdata;
  logic signed [DATA_BITS-1:0] mat_q_r;

  always_ff @(posedge clk) begin
    if (mat_we) mat_mem[mat_waddr] <= mat_wdata;
    mat_q_r <= mat_mem[mat_raddr];
  end

  // column order memory, invalid entries read as their own position
  logic [CW-1:0]       ord_mem [MAX_COLS];
  logic [MAX_COLS-1:0] ord_vld_r;
  logic                ord_we, ord_clr;
  logic [CW-1:0]       ord_waddr, ord_wdata, ord_raddr;
  logic [CW-1:0]       ord_q_r, ord_a_r;
  logic                ord_v_r;
  logic [CW-1:0]       ord_val;

  always_ff @(posedge clk) begin
    if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
    ord_q_r <= ord_mem[ord_raddr];
    ord_v_r <= ord_vld_r[ord_raddr];
    ord_a_r <= ord_raddr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ord_clr) begin
      ord_vld_r <= '0;
    end else if (ord_we) begin
      ord_vld_r[ord_waddr] <= 1'b1;
    end
  end

  assign ord_val = ord_v_r ? ord_q_r : ord_a_r;

  // sequencer registers
  state_t                      state_r, state_nxt;
  logic [4:0]                  row_r, row_nxt;
  logic [4:0]                  i_r, i_nxt;
  logic [4:0]                  j_r, j_nxt;
  logic [CW-1:0]               src_r, src_nxt;
  logic [CW-1:0]               c_r, c_nxt;
  logic [CW-1:0]               o_r, o_nxt;
  logic signed [DATA_BITS-1:0] k_r, k_nxt;

  // output register
  logic               out_valid_r;
  logic signed [15:0] out_read_value_r;
  logic [3:0]         out_source_column_r;
  logic [1:0]         out_status_r;
  logic               out_load;
  logic signed [15:0] out_read_value_nxt;
  logic [3:0]         out_source_column_nxt;
  logic [1:0]         out_status_nxt;

  logic in_fire;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    src_r <= src_nxt;
    c_r   <= c_nxt;
    o_r   <= o_nxt;
    k_r   <= k_nxt;
  end

  // next state, memory controls and result loading
  always_comb begin
    state_nxt             = state_r;
    row_nxt               = row_r;
    i_nxt                 = i_r;
    j_nxt                 = j_r;
    src_nxt               = src_r;
    c_nxt                 = c_r;
    o_nxt                 = o_r;
    k_nxt                 = k_r;
    mat_we                = 1'b0;
    mat_waddr             = mat_addr(in_row5, CW'(in_col5));
    mat_wdata             = DATA_BITS'(in_element_value);
    mat_raddr             = '0;
    ord_we                = 1'b0;
    ord_clr               = 1'b0;
    ord_waddr             = CW'(j_r);
    ord_wdata             = c_r;
    ord_raddr             = '0;
    out_load              = 1'b0;
    out_read_value_nxt    = '0;
    out_source_column_nxt = '0;
    out_status_nxt        = ST_WRITTEN;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_op)
            OP_WRITE: begin
              mat_we   = wr_ok;
              out_load = 1'b1;
            end
            OP_SORT: begin
              ord_clr   = 1'b1;
              i_nxt     = 5'd1;
              state_nxt = (eff_cols == 5'd1) ? S_DONE : S_SRT_I;
            end
            OP_READ: begin
              ord_raddr = CW'(rd_pos);
              row_nxt   = rd_row;
              state_nxt = S_RD_ORD;
            end
            default: ;
          endcase
        end
      end
      // read: source column known, fetch the element
      S_RD_ORD: begin
        src_nxt   = ord_val;
        mat_raddr = mat_addr(row_r, ord_val);
        state_nxt = S_RD_MAT;
      end
      S_RD_MAT: begin
        out_load              = 1'b1;
        out_read_value_nxt    = 16'(mat_q_r);
        out_source_column_nxt = 4'(src_r);
        out_status_nxt        = ST_READ_DATA;
        state_nxt             = S_IDLE;
      end
      // sort: pick up the column at position i
      S_SRT_I: begin
        ord_raddr = CW'(i_r);
        state_nxt = S_SRT_C;
      end
      S_SRT_C: begin
        c_nxt     = ord_val;
        mat_raddr = mat_addr(krow, ord_val);
        j_nxt     = i_r;
        state_nxt = S_SRT_K;
      end
      S_SRT_K: begin
        k_nxt     = mat_q_r;
        ord_raddr = CW'(j_r - 5'd1);
        state_nxt = S_SRT_O;
      end
      S_SRT_J: begin
        ord_raddr = CW'(j_r - 5'd1);
        state_nxt = S_SRT_O;
      end
      // sort: key of the column left of the hole
      S_SRT_O: begin
        o_nxt     = ord_val;
        mat_raddr = mat_addr(krow, ord_val);
        state_nxt = S_SRT_CMP;
      end
      // sort: strictly smaller key moves right, equal keys stay put
      S_SRT_CMP: begin
        if (mat_q_r < k_r) begin
          ord_we    = 1'b1;
          ord_wdata = o_r;
          j_nxt     = j_r - 5'd1;
          state_nxt = (j_r == 5'd1) ? S_SRT_PUT : S_SRT_J;
        end else begin
          state_nxt = S_SRT_PUT;
        end
      end
      S_SRT_PUT: begin
        ord_we    = 1'b1;
        ord_wdata = c_r;
        i_nxt     = i_r + 5'd1;
        state_nxt = ((i_r + 5'd1) == eff_cols) ? S_DONE : S_SRT_I;
      end
      S_DONE: begin
        out_load       = 1'b1;
        out_status_nxt = ST_SORT_DONE;
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_read_value_r    <= out_read_value_nxt;
      out_source_column_r <= out_source_column_nxt;
      out_status_r        <= out_status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_value    = out_read_value_r;
  assign out_source_column = out_source_column_r;
  assign out_status        = out_status_r;

`ifndef SYNTHESIS
  // a sort always starts from the identity order
  a_sort_clears_order: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_op == OP_SORT) |=> (ord_vld_r == '0))
    else $error("column order not cleared at sort start");

  // the hole index stays inside the sorted prefix
  a_hole_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRT_CMP) |-> (j_r != 5'd0 && j_r <= i_r))
    else $error("insertion hole out of range");

  // the outer index stays below the columns in use
  a_outer_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRT_I) |-> (i_r != 5'd0 && i_r < eff_cols))
    else $error("outer sort index out of range");

  // read and sort results never overwrite a waiting beat
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_MAT || state_r == S_DONE) |-> !out_valid_r)
    else $error("result register overwritten");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for column_sort_by_key_row
// holds the result tracker class, the beat drivers and the stimulus; depends on csbk_pkg
module tb;
  import csbk_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 20;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_ITEMS = 180;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic signed [15:0] value;
    logic [3:0]         src;
    logic [1:0]         status;
  } result_t;

  // tracks the stored matrix, the column order and the registers; predicts each result
  class sorted_view_tracker;
    logic signed [15:0] cells [16][16];
    logic [3:0]         order [16];
    logic [4:0]         rows_reg;
    logic [4:0]         cols_reg;
    logic [3:0]         key_reg;
    result_t            pending [$];
    int                 errors;
    int                 reports;

    function new();
      rows_reg = 5'd16;
      cols_reg = 5'd16;
      key_reg  = 4'd1;
      errors   = 0;
      reports  = 0;
      for (int i = 0; i < 16; i++) order[i] = 4'(i);
    endfunction

    function int live_rows();
      if (rows_reg == 0) return 1;
      return (rows_reg > 16) ? 16 : int'(rows_reg);
    endfunction

    function int live_cols();
      if (cols_reg == 0) return 1;
      return (cols_reg > 16) ? 16 : int'(cols_reg);
    endfunction

    function int live_key();
      return (key_reg >= live_rows()) ? live_rows() - 1 : int'(key_reg);
    endfunction

    function void set_register(logic [1:0] idx, logic [4:0] data);
      case (idx)
        CFG_ROWS_USED: rows_reg = data;
        CFG_COLS_USED: cols_reg = data;
        CFG_KEY_ROW:   key_reg  = data[3:0];
        default: ;
      endcase
    endfunction

    // each column lands after every column with a larger key and every
    // earlier column with an equal key
    function void rank_columns();
      int n;
      int kr;
      int pos;
      n  = live_cols();
      kr = live_key();
      for (int c = 0; c < 16; c++) order[c] = 4'(c);
      for (int c = 0; c < n; c++) begin
        pos = 0;
        for (int d = 0; d < n; d++) begin
          if (cells[kr][d] > cells[kr][c] || (cells[kr][d] == cells[kr][c] && d < c))
            pos++;
        end
        order[pos] = 4'(c);
      end
    endfunction

    function void take_beat(logic [1:0] op, logic [3:0] row, logic [3:0] col,
                            logic signed [15:0] value);
      result_t r;
      int rr;
      int cc;
      r = '0;
      case (op)
        OP_WRITE: begin
          if (row < live_rows() && col < live_cols()) cells[row][col] = value;
          r.status = ST_WRITTEN;
          pending.push_back(r);
        end
        OP_SORT: begin
          rank_columns();
          r.status = ST_SORT_DONE;
          pending.push_back(r);
        end
        OP_READ: begin
          rr = (row >= live_rows()) ? live_rows() - 1 : int'(row);
          cc = (col >= live_cols()) ? live_cols() - 1 : int'(col);
          r.src    = order[cc];
          r.value  = cells[rr][order[cc]];
          r.status = ST_READ_DATA;
          pending.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void flag(string what, int want, int got);
      errors++;
      if (reports < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      reports++;
    endfunction

    function void check_beat(logic signed [15:0] value, logic [3:0] src, logic [1:0] status);
      result_t want;
      if (pending.size() == 0) begin
        flag("unexpected result beat, status", -1, int'(status));
        return;
      end
      want = pending.pop_front();
      if (value !== want.value) flag("read_value", int'(want.value), int'(value));
      if (src !== want.src) flag("source_column", int'(want.src), int'(src));
      if (status !== want.status) flag("status", int'(want.status), int'(status));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [4:0]         cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_op = '0;
  logic [3:0]         in_row_index = '0;
  logic [3:0]         in_col_index = '0;
  logic signed [15:0] in_element_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_read_value;
  logic [3:0]         out_source_column;
  logic [1:0]         out_status;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  sorted_view_tracker tracker;

  column_sort_by_key_row DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_row_index      (in_row_index),
    .in_col_index      (in_col_index),
    .in_element_value  (in_element_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_value    (out_read_value),
    .out_source_column (out_source_column),
    .out_status        (out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // observe accepted beats and register writes
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) tracker.check_beat(out_read_value, out_source_column, out_status);
      if (in_valid && in_ready)
        tracker.take_beat(in_op, in_row_index, in_col_index, in_element_value);
      if (cfg_we) tracker.set_register(cfg_index, cfg_wdata);
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ties, extremes, or anything
  function automatic logic [15:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 25) return 16'($urandom_range(3)) - 16'd1;
    if (r < 35) return ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
    return 16'($urandom_range(65535));
  endfunction

  task automatic send_beat(logic [1:0] op, logic [3:0] row, logic [3:0] col, logic [15:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_row_index     <= row;
    in_col_index     <= col;
    in_element_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold off the sender until every result is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(logic [4:0] rows, logic [4:0] cols, logic [3:0] key);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROWS_USED;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_index <= CFG_COLS_USED;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_index <= CFG_KEY_ROW;
    cfg_wdata <= {1'b0, key};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [4:0] rows_tab [8];
    logic [4:0] cols_tab [8];
    logic [3:0] key_tab [8];
    int counted;
    int burst;
    int op_pick;
    logic [1:0] op;

    tracker = new();
    rows_tab = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd2, 5'd16, 5'd9};
    cols_tab = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd9, 5'd16, 5'd2, 5'd12};
    key_tab  = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd4, 4'd1, 4'd15, 4'd7};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every element once so no read ever touches an unwritten cell
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++) send_beat(OP_WRITE, 4'(r), 4'(c), pick_value());

    // directed: ties and extremes on the key row, identity before a sort
    send_beat(OP_WRITE, 4'd1, 4'd0, 16'd7);
    send_beat(OP_WRITE, 4'd1, 4'd1, 16'd7);
    send_beat(OP_WRITE, 4'd1, 4'd2, 16'h7FFF);
    send_beat(OP_WRITE, 4'd1, 4'd3, 16'h8000);
    send_beat(OP_WRITE, 4'd1, 4'd4, 16'hFFFF);
    send_beat(OP_READ, 4'd0, 4'd0, 16'h0);
    send_beat(OP_SORT, 4'd0, 4'd0, 16'h0);
    send_beat(OP_READ, 4'd1, 4'd0, 16'h0);
    send_beat(OP_READ, 4'd1, 4'd1, 16'h0);
    send_beat(OP_READ, 4'd1, 4'd2, 16'h0);
    send_beat(OP_READ, 4'd15, 4'd15, 16'h0);
    send_beat(OP_UNUSED, 4'd15, 4'd15, 16'hFFFF);
    drain();

    // zero rows act as one, key row saturates, write outside rows is dropped
    load_settings(5'd0, 5'd31, 4'd15);
    send_beat(OP_WRITE, 4'd3, 4'd2, 16'h1234);
    send_beat(OP_WRITE, 4'd0, 4'd15, 16'h8000);
    send_beat(OP_SORT, 4'd0, 4'd0, 16'h0);
    send_beat(OP_READ, 4'd9, 4'd15, 16'h0);
    send_beat(OP_READ, 4'd0, 4'd0, 16'h0);
    drain();

    // single column: order kept until the next sort, reads saturate
    load_settings(5'd31, 5'd0, 4'd0);
    send_beat(OP_READ, 4'd4, 4'd9, 16'h0);
    send_beat(OP_WRITE, 4'd2, 4'd5, 16'h5555);
    send_beat(OP_SORT, 4'd0, 4'd0, 16'h0);
    send_beat(OP_READ, 4'd15, 4'd15, 16'h0);
    drain();

    // random phases across settings and idling patterns
    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 8) begin
        load_settings(rows_tab[ph], cols_tab[ph], key_tab[ph]);
      end else begin
        load_settings(5'($urandom_range(31)), 5'($urandom_range(31)), 4'($urandom_range(15)));
      end
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        if ($urandom_range(99) < 65) begin
          // key row updates, a sort, then reads of the permuted view
          burst = $urandom_range(6);
          for (int k = 0; k < burst; k++) begin
            send_beat(OP_WRITE, 4'(tracker.live_key()),
                      4'($urandom_range(tracker.live_cols() - 1)), pick_value());
          end
          counted += burst;
          send_beat(OP_SORT, 4'($urandom_range(15)), 4'($urandom_range(15)), pick_value());
          burst = $urandom_range(1, 8);
          for (int k = 0; k < burst; k++) begin
            send_beat(OP_READ, 4'($urandom_range(15)), 4'($urandom_range(15)), pick_value());
          end
          counted += 1 + burst;
        end else begin
          op_pick = $urandom_range(99);
          if (op_pick < 45) op = OP_WRITE;
          else if (op_pick < 55) op = OP_SORT;
          else if (op_pick < 92) op = OP_READ;
          else op = OP_UNUSED;
          send_beat(op, 4'($urandom_range(15)), 4'($urandom_range(15)), pick_value());
          if (op != OP_UNUSED) counted++;
        end
      end
      drain();
    end

    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
